// ===== rtl/drar_pkg.sv =====
// Shared types, constants and arbitration functions of the deflection router arbitration block.
`timescale 1ns / 1ps
`default_nettype none
package drar_pkg;

  localparam int unsigned NumSlots   = 4;
  localparam int unsigned SlotBits   = 22;
  localparam int unsigned PrioBits   = 16;
  localparam int unsigned PosBits    = 4;
  localparam int unsigned MaxPos     = 8;
  localparam int unsigned AddrBits   = 3;
  localparam int unsigned DataBits   = 32;

  // Register index decoded from the byte address
  localparam logic RegPosition = 1'b0;
  localparam logic [PosBits-1:0] PosReset = 4'd4;

  // Field positions inside one packed link slot
  localparam int unsigned SlotValid  = 0;
  localparam int unsigned SlotGolden = 1;
  localparam int unsigned SlotLocal  = 2;
  localparam int unsigned SlotWantLo = 3;
  localparam int unsigned SlotPrioLo = 6;

  typedef logic [NumSlots-1:0][SlotBits-1:0] slot_vec_t;

  // One flit as seen by the permutation network; src 0 means empty
  typedef struct packed {
    logic [2:0]          src;
    logic                gold;
    logic [2:0]          want;
    logic [PrioBits-1:0] pri;
  } cell_t;

  typedef cell_t [NumSlots-1:0] cells_t;

  // Classified router cycle handed from front to back
  typedef struct packed {
    cells_t     cells;
    logic       eject_valid;
    logic [1:0] eject_slot;
    logic       inject_taken;
    logic [1:0] inject_slot;
  } item_t;

  // One two-slot arbiter of the permutation chain
  typedef struct packed {
    logic       en;
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] split;
  } arb_t;

  // Slots that may take an injected flit, per mesh position
  function automatic logic [NumSlots-1:0] inject_legal(input logic [PosBits-1:0] pos);
    logic [NumSlots-1:0] m;
    case (pos)
      4'd0:    m = 4'h5;
      4'd1:    m = 4'h7;
      4'd2:    m = 4'h6;
      4'd3:    m = 4'hE;
      4'd4:    m = 4'hF;
      4'd5:    m = 4'hD;
      4'd6:    m = 4'h9;
      4'd7:    m = 4'hB;
      4'd8:    m = 4'hA;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic arb_t mk_arb(input logic [1:0] a, input logic [1:0] b,
                                  input logic [1:0] split);
    arb_t r;
    r.en = 1'b1;
    r.a = a;
    r.b = b;
    r.split = split;
    return r;
  endfunction

  // Fixed arbiter chain per mesh position; unused steps are disabled
  function automatic arb_t arb_stage(input logic [PosBits-1:0] pos, input logic [1:0] idx);
    arb_t r;
    r = '0;
    case (pos)
      4'd0: begin
        if (idx == 2'd0) r = mk_arb(2'd2, 2'd0, 2'd1);
      end
      4'd1: begin
        case (idx)
          2'd0:    r = mk_arb(2'd2, 2'd0, 2'd1);
          2'd1:    r = mk_arb(2'd2, 2'd1, 2'd1);
          2'd2:    r = mk_arb(2'd1, 2'd0, 2'd0);
          default: r = '0;
        endcase
      end
      4'd2: begin
        if (idx == 2'd0) r = mk_arb(2'd2, 2'd1, 2'd1);
      end
      4'd3: begin
        case (idx)
          2'd0:    r = mk_arb(2'd3, 2'd1, 2'd1);
          2'd1:    r = mk_arb(2'd2, 2'd1, 2'd1);
          2'd2:    r = mk_arb(2'd3, 2'd2, 2'd2);
          default: r = '0;
        endcase
      end
      4'd4: begin
        case (idx)
          2'd0:    r = mk_arb(2'd2, 2'd0, 2'd1);
          2'd1:    r = mk_arb(2'd3, 2'd1, 2'd1);
          2'd2:    r = mk_arb(2'd3, 2'd2, 2'd2);
          default: r = mk_arb(2'd1, 2'd0, 2'd0);
        endcase
      end
      4'd5: begin
        case (idx)
          2'd0:    r = mk_arb(2'd2, 2'd0, 2'd1);
          2'd1:    r = mk_arb(2'd3, 2'd0, 2'd1);
          2'd2:    r = mk_arb(2'd3, 2'd2, 2'd2);
          default: r = '0;
        endcase
      end
      4'd6: begin
        if (idx == 2'd0) r = mk_arb(2'd3, 2'd0, 2'd2);
      end
      4'd7: begin
        case (idx)
          2'd0:    r = mk_arb(2'd3, 2'd1, 2'd1);
          2'd1:    r = mk_arb(2'd3, 2'd0, 2'd1);
          2'd2:    r = mk_arb(2'd1, 2'd0, 2'd0);
          default: r = '0;
        endcase
      end
      4'd8: begin
        if (idx == 2'd0) r = mk_arb(2'd3, 2'd1, 2'd2);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Two-slot arbiter: winner steers to b when its wanted port is at most split
  function automatic cells_t arbitrate(input cells_t c, input arb_t st);
    cells_t     r;
    logic       has_a;
    logic       has_b;
    logic       a_wins;
    logic [2:0] want;
    logic       to_b;
    r = c;
    has_a = (c[st.a].src != 3'd0);
    has_b = (c[st.b].src != 3'd0);
    if (!has_b) begin
      a_wins = 1'b1;
    end else if (!has_a) begin
      a_wins = 1'b0;
    end else if (c[st.a].gold != c[st.b].gold) begin
      a_wins = c[st.a].gold;
    end else begin
      a_wins = (c[st.a].pri >= c[st.b].pri);
    end
    want = a_wins ? c[st.a].want : c[st.b].want;
    to_b = (want <= {1'b0, st.split});
    if (st.en && (has_a || has_b) && (a_wins == to_b)) begin
      r[st.a] = c[st.b];
      r[st.b] = c[st.a];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/drar_front.sv =====
// Front end: decode link slots, pick the ejected flit and place the injected flit.
`timescale 1ns / 1ps
`default_nettype none
module drar_front (
  input  drar_pkg::slot_vec_t              slot_i,
  input  logic                             inject_valid_i,
  input  logic                             inject_golden_i,
  input  logic [2:0]                       inject_port_i,
  input  logic [drar_pkg::PrioBits-1:0]    inject_priority_i,
  input  logic [drar_pkg::PosBits-1:0]     pos_i,
  output drar_pkg::item_t                  item_o
);
  import drar_pkg::*;

  cells_t              cells;
  cells_t              cells_ej;
  logic [NumSlots-1:0] loc;
  logic [1:0]          ej_idx;
  logic                ej_gold;
  logic                ej_any;
  logic                ej_found;
  logic [NumSlots-1:0] legal;
  logic [1:0]          inj_idx;
  logic                inj_found;

  // Decode each slot; an invalid slot is empty
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      cells[i].src  = slot_i[i][SlotValid] ? 3'(i + 1) : 3'd0;
      cells[i].gold = slot_i[i][SlotGolden];
      cells[i].want = slot_i[i][SlotWantLo +: 3];
      cells[i].pri  = slot_i[i][SlotPrioLo +: PrioBits];
      loc[i]        = slot_i[i][SlotValid] & slot_i[i][SlotLocal];
    end
  end

  // Pick the ejected flit: golden first, then oldest, first wins ties
  always_comb begin
    ej_idx  = 2'd0;
    ej_gold = 1'b0;
    ej_any  = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      if (loc[i] && cells[i].gold && (!ej_gold || cells[i].pri > cells[ej_idx].pri)) begin
        ej_idx  = 2'(i);
        ej_gold = 1'b1;
      end
    end
    if (!ej_gold) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (loc[i] && (!ej_any || cells[i].pri > cells[ej_idx].pri)) begin
          ej_idx = 2'(i);
          ej_any = 1'b1;
        end
      end
    end
    ej_found = ej_gold | ej_any;
  end

  // Drop the ejected flit and inject into the first free legal slot
  always_comb begin
    cells_ej = cells;
    if (ej_found) cells_ej[ej_idx].src = 3'd0;
    legal     = inject_legal(pos_i);
    inj_idx   = 2'd0;
    inj_found = 1'b0;
    if (inject_valid_i && (pos_i <= PosBits'(MaxPos))) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (!inj_found && cells_ej[i].src == 3'd0 && legal[i]) begin
          inj_idx   = 2'(i);
          inj_found = 1'b1;
        end
      end
    end
    item_o.cells = cells_ej;
    if (inj_found) begin
      item_o.cells[inj_idx].src  = {1'b0, inj_idx} + 3'd1;
      item_o.cells[inj_idx].gold = inject_golden_i;
      item_o.cells[inj_idx].want = inject_port_i;
      item_o.cells[inj_idx].pri  = inject_priority_i;
    end
    item_o.eject_valid  = ej_found;
    item_o.eject_slot   = ej_found ? ej_idx : 2'd0;
    item_o.inject_taken = inj_found;
    item_o.inject_slot  = inj_found ? inj_idx : 2'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/drar_queue.sv =====
// Two-entry queue of classified router cycles between front and back.
`timescale 1ns / 1ps
`default_nettype none
module drar_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  drar_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            rd_i,
  output drar_pkg::item_t rd_item_o,
  output logic            empty_o
);
  import drar_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr;
  logic       do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue occupancy out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue lost a write");

endmodule
`default_nettype wire

// ===== rtl/drar_back.sv =====
// Back end: two-stage permutation pipeline with the result register.
`timescale 1ns / 1ps
`default_nettype none
module drar_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [drar_pkg::PosBits-1:0] pos_i,
  input  logic                         in_valid_i,
  input  drar_pkg::item_t              in_item_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  output drar_pkg::item_t              out_item_o,
  input  logic                         out_pop_i
);
  import drar_pkg::*;

  item_t mid_q, mid_d;
  logic  mid_v_q;
  item_t out_q, out_d;
  logic  out_v_q;
  logic  out_ready;
  logic  mid_ready;

  assign out_ready  = ~out_v_q | out_pop_i;
  assign mid_ready  = ~mid_v_q | out_ready;
  assign in_ready_o = mid_ready;

  // First half of the arbiter chain
  always_comb begin
    mid_d       = in_item_i;
    mid_d.cells = arbitrate(in_item_i.cells, arb_stage(pos_i, 2'd0));
    mid_d.cells = arbitrate(mid_d.cells, arb_stage(pos_i, 2'd1));
  end

  // Second half of the arbiter chain
  always_comb begin
    out_d       = mid_q;
    out_d.cells = arbitrate(mid_q.cells, arb_stage(pos_i, 2'd2));
    out_d.cells = arbitrate(out_d.cells, arb_stage(pos_i, 2'd3));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (mid_ready) mid_v_q <= in_valid_i;
      if (out_ready) out_v_q <= mid_v_q;
    end
  end

  // Advance payload on each stage's handshake
  always_ff @(posedge clk_i) begin
    if (mid_ready && in_valid_i) mid_q <= mid_d;
    if (out_ready && mid_v_q) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_v_q |->
    ((out_q.cells[0].src == 3'd0 || out_q.cells[0].src != out_q.cells[1].src) &&
     (out_q.cells[0].src == 3'd0 || out_q.cells[0].src != out_q.cells[2].src) &&
     (out_q.cells[0].src == 3'd0 || out_q.cells[0].src != out_q.cells[3].src) &&
     (out_q.cells[1].src == 3'd0 || out_q.cells[1].src != out_q.cells[2].src) &&
     (out_q.cells[1].src == 3'd0 || out_q.cells[1].src != out_q.cells[3].src) &&
     (out_q.cells[2].src == 3'd0 || out_q.cells[2].src != out_q.cells[3].src)))
    else $error("one slot feeds two output ports");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.eject_valid) |-> (out_q.eject_slot == 2'd0))
    else $error("eject slot set without eject");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.inject_taken) |-> (out_q.inject_slot == 2'd0))
    else $error("inject slot set without injection");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_v_q && !out_ready) |=> (mid_v_q && $stable(mid_q)))
    else $error("middle stage changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/deflection_router_arbitration.sv =====
// A transaction passes the middle stage register and then the result register.
// Throughput: one transaction per cycle while results are popped; the two-entry front queue
// and the two permutation stages of the back end each take a new router cycle every clock unless full or stalled.
// The arbiter chain is split over the two back-end stages, two arbiters each.
// Reset clears the queue and pipeline; router_position resets to interior (4).
`timescale 1ns / 1ps
`default_nettype none
module deflection_router_arbitration (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [drar_pkg::AddrBits-1:0]   paddr,
  input  logic [drar_pkg::DataBits-1:0]   pwdata,
  output logic [drar_pkg::DataBits-1:0]   prdata,
  output logic                            pready,
  // Input side
  input  logic                            push,
  output logic                            full,
  input  logic [drar_pkg::SlotBits-1:0]   slot0_i,
  input  logic [drar_pkg::SlotBits-1:0]   slot1_i,
  input  logic [drar_pkg::SlotBits-1:0]   slot2_i,
  input  logic [drar_pkg::SlotBits-1:0]   slot3_i,
  input  logic                            inject_valid_i,
  input  logic                            inject_golden_i,
  input  logic [2:0]                      inject_port_i,
  input  logic [drar_pkg::PrioBits-1:0]   inject_priority_i,
  // Result side
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      out0_source_o,
  output logic [2:0]                      out1_source_o,
  output logic [2:0]                      out2_source_o,
  output logic [2:0]                      out3_source_o,
  output logic                            eject_valid_o,
  output logic [1:0]                      eject_slot_o,
  output logic                            inject_taken_o,
  output logic [1:0]                      inject_slot_o
);
  import drar_pkg::*;

  logic [PosBits-1:0] pos_q;
  logic               reg_idx;
  slot_vec_t          slots;
  item_t              front_item;
  item_t              q_item;
  logic               q_empty;
  logic               back_ready;
  logic               back_valid;
  item_t              res_item;

  // Config register
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrBits-1];
  assign prdata  = (reg_idx == RegPosition) ? DataBits'(pos_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosReset;
    end else if (psel && penable && pwrite && pready && reg_idx == RegPosition) begin
      pos_q <= pwdata[PosBits-1:0];
    end
  end

  assign slots = {slot3_i, slot2_i, slot1_i, slot0_i};

  drar_front u_front (
    .slot_i            (slots),
    .inject_valid_i    (inject_valid_i),
    .inject_golden_i   (inject_golden_i),
    .inject_port_i     (inject_port_i),
    .inject_priority_i (inject_priority_i),
    .pos_i             (pos_q),
    .item_o            (front_item)
  );

  drar_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_item_i (front_item),
    .full_o    (full),
    .rd_i      (back_ready),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  drar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_i       (pos_q),
    .in_valid_i  (~q_empty),
    .in_item_i   (q_item),
    .in_ready_o  (back_ready),
    .out_valid_o (back_valid),
    .out_item_o  (res_item),
    .out_pop_i   (pop)
  );

  assign empty          = ~back_valid;
  assign out0_source_o  = res_item.cells[0].src;
  assign out1_source_o  = res_item.cells[1].src;
  assign out2_source_o  = res_item.cells[2].src;
  assign out3_source_o  = res_item.cells[3].src;
  assign eject_valid_o  = res_item.eject_valid;
  assign eject_slot_o   = res_item.eject_slot;
  assign inject_taken_o = res_item.inject_taken;
  assign inject_slot_o  = res_item.inject_slot;

endmodule
`default_nettype wire
